// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] priority_req;
    logic        [31:0] data_handle;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [31:0] out_handle;
    logic signed [15:0] out_priority;
    logic               head_valid;
    logic        [4:0]  count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_HEAD,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/spq_ram.sv =====
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of DEPTH entries, highest priority at the head; a new
// entry goes behind every entry of higher priority and in front of equals.
// Entries sit in a single-port-write, single-port-read RAM used as a circular
// buffer, with a copy of the head kept in registers. One item is handled at a
// time. A dequeue loads the new head from the RAM when entries remain. An
// insert into an empty or full queue goes straight to the response; otherwise
// the RAM moves every entry that sits at or below the new priority one slot
// toward the tail, one entry per cycle. Results leave through an output
// register, so a stalled result does not hold up the next request beyond
// that item.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);

  localparam int PW = (PRIO_BITS < 16) ? PRIO_BITS : 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PW + 32;

  spq_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   base, base_next;
  logic [AW-1:0]   idx, idx_next;
  logic [PW-1:0]   new_prio, new_prio_next;
  logic [31:0]     new_handle, new_handle_next;
  logic [PW-1:0]   head_prio, head_prio_next;
  logic [31:0]     head_handle, head_handle_next;
  spq_pkg::rsp_t   res, res_next;
  spq_pkg::rsp_t   rsp_next;
  logic            rsp_valid_next;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [PW-1:0]   rd_prio;
  logic [31:0]     rd_handle;
  logic [CW-1:0]   count_inc, count_dec;
  logic [PW-1:0]   req_prio;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, b} + {1'b0, l};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic signed [15:0] ext_prio(input logic [PW-1:0] p);
    return 16'($signed(p));
  endfunction

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_prio   = rdata[EW-1:32];
  assign rd_handle = rdata[31:0];
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign req_prio  = req.priority_req[PW-1:0];
  assign req_stall = (state != spq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      count     <= '0;
      base      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      base      <= base_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    new_prio    <= new_prio_next;
    new_handle  <= new_handle_next;
    head_prio   <= head_prio_next;
    head_handle <= head_handle_next;
    res         <= res_next;
    rsp         <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    base_next        = base;
    idx_next         = idx;
    new_prio_next    = new_prio;
    new_handle_next  = new_handle;
    head_prio_next   = head_prio;
    head_handle_next = head_handle;
    res_next         = res;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && rsp_stall;
    we               = 1'b0;
    waddr            = phys(base, idx);
    wdata            = rdata;
    re               = 1'b0;
    raddr            = phys(base, idx - AW'(1));

    case (state)
      spq_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == spq_pkg::CMD_INSERT) begin
            if (count == CW'(DEPTH)) begin
              res_next.status       = spq_pkg::STATUS_FULL;
              res_next.out_handle   = head_handle;
              res_next.out_priority = ext_prio(head_prio);
              res_next.head_valid   = 1'b1;
              res_next.count        = 5'(count);
              state_next            = spq_pkg::ST_RESP;
            end else if (count == '0) begin
              we                    = 1'b1;
              waddr                 = phys(base, '0);
              wdata                 = {req_prio, req.data_handle};
              head_prio_next        = req_prio;
              head_handle_next      = req.data_handle;
              count_next            = count_inc;
              res_next.status       = spq_pkg::STATUS_DONE;
              res_next.out_handle   = req.data_handle;
              res_next.out_priority = ext_prio(req_prio);
              res_next.head_valid   = 1'b1;
              res_next.count        = 5'(count_inc);
              state_next            = spq_pkg::ST_RESP;
            end else begin
              // Walk from the tail toward the head, reading one entry ahead.
              new_prio_next   = req_prio;
              new_handle_next = req.data_handle;
              idx_next        = count[AW-1:0];
              re              = 1'b1;
              raddr           = phys(base, count[AW-1:0] - AW'(1));
              state_next      = spq_pkg::ST_SHIFT;
            end
          end else begin
            if (count == '0) begin
              res_next.status       = spq_pkg::STATUS_EMPTY;
              res_next.out_handle   = '0;
              res_next.out_priority = '0;
              res_next.head_valid   = 1'b0;
              res_next.count        = '0;
              state_next            = spq_pkg::ST_RESP;
            end else begin
              res_next.status       = spq_pkg::STATUS_DONE;
              res_next.out_handle   = head_handle;
              res_next.out_priority = ext_prio(head_prio);
              res_next.head_valid   = 1'b1;
              res_next.count        = 5'(count_dec);
              count_next            = count_dec;
              base_next             = phys(base, AW'(1));
              if (count > CW'(1)) begin
                re         = 1'b1;
                raddr      = phys(base, AW'(1));
                state_next = spq_pkg::ST_HEAD;
              end else begin
                state_next = spq_pkg::ST_RESP;
              end
            end
          end
        end
      end

      spq_pkg::ST_SHIFT: begin
        if ($signed(rd_prio) <= $signed(new_prio)) begin
          // The entry ahead does not outrank the new one: move it back a slot.
          we       = 1'b1;
          waddr    = phys(base, idx);
          wdata    = rdata;
          idx_next = idx - AW'(1);
          if (idx == AW'(1)) begin
            state_next = spq_pkg::ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = phys(base, idx - AW'(2));
          end
        end else begin
          we                    = 1'b1;
          waddr                 = phys(base, idx);
          wdata                 = {new_prio, new_handle};
          count_next            = count_inc;
          res_next.status       = spq_pkg::STATUS_DONE;
          res_next.out_handle   = head_handle;
          res_next.out_priority = ext_prio(head_prio);
          res_next.head_valid   = 1'b1;
          res_next.count        = 5'(count_inc);
          state_next            = spq_pkg::ST_RESP;
        end
      end

      spq_pkg::ST_PLACE: begin
        we                    = 1'b1;
        waddr                 = phys(base, '0);
        wdata                 = {new_prio, new_handle};
        head_prio_next        = new_prio;
        head_handle_next      = new_handle;
        count_next            = count_inc;
        res_next.status       = spq_pkg::STATUS_DONE;
        res_next.out_handle   = new_handle;
        res_next.out_priority = ext_prio(new_prio);
        res_next.head_valid   = 1'b1;
        res_next.count        = 5'(count_inc);
        state_next            = spq_pkg::ST_RESP;
      end

      spq_pkg::ST_HEAD: begin
        head_prio_next   = rd_prio;
        head_handle_next = rd_handle;
        state_next       = spq_pkg::ST_RESP;
      end

      spq_pkg::ST_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = spq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  `SPQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_no_rw_collide, clk, rst, !(we && re && (waddr == raddr)), "RAM read and write hit the same entry")
  `SPQ_ASSERT_IMPLY(a_empty_rsp, clk, rst, rsp_valid && (rsp.status == spq_pkg::STATUS_EMPTY), !rsp.head_valid && (rsp.count == 5'd0), "empty status with entries reported")
  `SPQ_ASSERT_IMPLY(a_busy_stall, clk, rst, state != spq_pkg::ST_IDLE, req_stall, "request taken while an item is in progress")

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// Mirror of the queue contents; it predicts the response to every request that
// is transferred in and checks the responses in order.
class pq_mirror;
  localparam int CAPACITY = 16;

  logic signed [15:0] slot_prio [CAPACITY];
  logic        [31:0] slot_handle [CAPACITY];
  int fill;
  spq_pkg::rsp_t expected_rsp [$];

  int errors;
  int requests;
  int responses;
  int full_refusals;
  int empty_refusals;
  int tie_inserts;
  int peak_fill;

  function void note_request(spq_pkg::req_t r);
    spq_pkg::rsp_t e;
    logic signed [15:0] p;
    int pos;
    int i;
    e = '0;
    p = r.priority_req;
    requests++;
    if (r.cmd == spq_pkg::CMD_INSERT) begin
      if (fill == CAPACITY) begin
        e.status = spq_pkg::STATUS_FULL;
        full_refusals++;
      end else begin
        // The new entry goes behind strictly higher priorities only.
        pos = 0;
        while (pos < fill && slot_prio[pos] > p) pos++;
        if (pos < fill && slot_prio[pos] == p) tie_inserts++;
        for (i = fill; i > pos; i--) begin
          slot_prio[i] = slot_prio[i - 1];
          slot_handle[i] = slot_handle[i - 1];
        end
        slot_prio[pos] = p;
        slot_handle[pos] = r.data_handle;
        fill++;
        if (fill > peak_fill) peak_fill = fill;
        e.status = spq_pkg::STATUS_DONE;
      end
      e.out_handle = slot_handle[0];
      e.out_priority = slot_prio[0];
      e.head_valid = 1'b1;
    end else if (fill == 0) begin
      e.status = spq_pkg::STATUS_EMPTY;
      empty_refusals++;
    end else begin
      e.status = spq_pkg::STATUS_DONE;
      e.out_handle = slot_handle[0];
      e.out_priority = slot_prio[0];
      e.head_valid = 1'b1;
      for (i = 1; i < fill; i++) begin
        slot_prio[i - 1] = slot_prio[i];
        slot_handle[i - 1] = slot_handle[i];
      end
      fill--;
    end
    e.count = 5'(fill);
    expected_rsp.push_back(e);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_response(spq_pkg::rsp_t got);
    spq_pkg::rsp_t want;
    responses++;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                responses));
    end else begin
      want = expected_rsp.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                  responses, got.status, want.status));
      if (got.out_handle !== want.out_handle)
        report_mismatch($sformatf("response %0d out_handle %h, expected %h",
                                  responses, got.out_handle, want.out_handle));
      if (got.out_priority !== want.out_priority)
        report_mismatch($sformatf("response %0d out_priority %0d, expected %0d",
                                  responses, got.out_priority, want.out_priority));
      if (got.head_valid !== want.head_valid)
        report_mismatch($sformatf("response %0d head_valid %b, expected %b",
                                  responses, got.head_valid, want.head_valid));
      if (got.count !== want.count)
        report_mismatch($sformatf("response %0d count %0d, expected %0d",
                                  responses, got.count, want.count));
    end
  endtask

  task check_drained();
    if (expected_rsp.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
  endtask
endclass

module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  spq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  spq_pkg::rsp_t rsp;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;
  pq_mirror mirror = new;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both channels are sampled here with the values they held before the edge.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      if (req_valid && !req_stall) mirror.note_request(req);
      if (rsp_valid && !rsp_stall) mirror.check_response(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(logic cmd, logic signed [15:0] prio, logic [31:0] handle);
    spq_pkg::req_t item;
    item.cmd = cmd;
    item.priority_req = prio;
    item.data_handle = handle;
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Holds the request side quiet until every outstanding response is back.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (mirror.expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int insert_pct);
    logic signed [15:0] prio;
    case ($urandom_range(9))
      0: prio = 16'sh7FFF;
      1: prio = 16'sh8000;
      // A narrow band of values keeps equal priorities common.
      2, 3, 4: prio = $signed(16'($urandom_range(3))) - 16'sd2;
      default: prio = 16'($urandom());
    endcase
    send_request(($urandom_range(99) < insert_pct) ?
                 spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
                 prio, $urandom());
  endtask

  initial begin
    int phase;
    int seg;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(spq_pkg::CMD_REMOVE, 16'sd0, 32'h0000_0000);
    send_request(spq_pkg::CMD_INSERT, 16'sh8000, 32'h0000_0000);
    send_request(spq_pkg::CMD_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
    send_request(spq_pkg::CMD_INSERT, 16'sd0, 32'h1111_1111);
    // The newer of two equal priorities must come out first.
    send_request(spq_pkg::CMD_INSERT, 16'sd0, 32'h2222_2222);
    for (n = 0; n < 12; n++)
      send_request(spq_pkg::CMD_INSERT, (n % 2) ? -16'sd1 : 16'sh8000,
                   32'hC000_0000 + n);
    send_request(spq_pkg::CMD_INSERT, 16'sh7FFF, 32'hDEAD_BEEF);
    for (n = 0; n < 3; n++) send_request(spq_pkg::CMD_REMOVE, 16'shFFFF, 32'hFFFF_FFFF);
    drain_results();

    // Segments alternate between filling and emptying so that both the full
    // and the empty queue are reached often.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      for (seg = 0; seg < 10; seg++)
        for (n = 0; n < 40; n++)
          send_random((seg % 5 == 4) ? 50 : ((seg % 2 == 0) ? 78 : 22));
      drain_results();
    end

    repeat (30) @(posedge clk);
    mirror.check_drained();
    $display("run summary: %0d requests, %0d responses, %0d mismatches",
             mirror.requests, mirror.responses, mirror.errors);
    $display("run summary: %0d full refusals, %0d empty refusals, %0d ties, peak %0d",
             mirror.full_refusals, mirror.empty_refusals, mirror.tie_inserts,
             mirror.peak_fill);
    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end
endmodule
